// File: hw/rtl/tlnvf_pkg.sv
// tlnvf_pkg: shared types and constants of the line numbering text filter
// used by the front, queue, back and top level files; depends on nothing

package tlnvf_pkg;

    // width of the run position and length fields, enough for runs up to 16 bytes
    localparam int IDX_W = 4;

    // line number is padded with spaces to this width
    localparam int PAD_WIDTH = 6;

    // depth of the job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CONTROL  = 3'd4;
    localparam int CFG_DATA_W = 2;

    // numbering modes; the spare code behaves as nonblank
    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;
    localparam logic [1:0] NUM_SPARE    = 2'd3;

    // character codes
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NL        = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_DOLLAR    = 8'd36;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] CH_QMARK     = 8'd63;
    localparam logic [7:0] CH_I         = 8'd73;
    localparam logic [7:0] CH_CARET     = 8'd94;
    localparam logic [7:0] CH_DEL       = 8'd127;
    localparam logic [7:0] CTRL_MAX     = 8'd31;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    // one classified item as the back expands it; the digits travel beside it
    typedef struct packed {
        logic             empty;     // squeezed line, one void byte
        logic [IDX_W-1:0] pad;       // run positions below this are spaces
        logic [IDX_W-1:0] dig_end;   // positions below this are digits
        logic [IDX_W-1:0] num_end;   // positions below this are the suffix
        logic [IDX_W-1:0] last_idx;  // position of the final byte
        logic [7:0]       suffix;
        logic [7:0]       body0;
        logic [7:0]       body1;
    } t_job;

endpackage

// File: hw/rtl/tlnvf_in_if.sv
// tlnvf_in_if: input channel of the line numbering filter (valid, ready, payload)
// no dependencies

interface tlnvf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

// File: hw/rtl/tlnvf_out_if.sv
// tlnvf_out_if: output channel of the line numbering filter (valid, ready, payload)
// no dependencies

interface tlnvf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       run_empty;

    modport source (output valid, output out_byte, output run_last, output run_empty,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input run_empty,
                  output ready);
endinterface

// File: hw/rtl/tlnvf_queue.sv
// tlnvf_queue: small register queue carrying jobs from front to back
// depends on tlnvf_pkg

module tlnvf_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_avail,
    output logic [DATA_W-1:0] o_data
);
    import tlnvf_pkg::*;

    logic [DATA_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: hw/rtl/tlnvf_front.sv
// tlnvf_front: accepts input items, keeps line state and the bcd line counter,
// classifies each item into a job; depends on tlnvf_pkg and tlnvf_in_if

module tlnvf_front #(
    parameter int COUNT_DIGITS = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tlnvf_in_if.sink                  i_in,
    input  logic [1:0]                i_number_mode,
    input  logic                      i_squeeze_blank,
    input  logic                      i_show_ends,
    input  logic                      i_show_tabs,
    input  logic                      i_show_control,
    input  logic                      i_q_full,
    output logic                      o_push,
    output tlnvf_pkg::t_job           o_job,
    output logic [4*COUNT_DIGITS-1:0] o_digits
);
    import tlnvf_pkg::*;

    localparam int DIG_W = 4 * COUNT_DIGITS;
    localparam logic [DIG_W-1:0] COUNT_ONE = DIG_W'(1);

    logic [DIG_W-1:0] r_digits;
    logic             r_at_start;
    logic             r_last_empty;
    logic [DIG_W-1:0] n_digits;
    logic             n_at_start;
    logic             n_last_empty;

    logic [DIG_W-1:0] eff_digits;
    logic [DIG_W-1:0] bumped;
    logic             eff_start;
    logic             eff_last_empty;
    logic             is_nl;
    logic             caret;
    logic             squeeze;
    logic             do_num;
    logic             all_nine;
    logic             carry;
    logic [3:0]       dig;
    logic [IDX_W-1:0] sig;
    logic [IDX_W-1:0] pad;
    logic [IDX_W-1:0] suffix_len;
    logic [IDX_W-1:0] num_end;
    logic [IDX_W-1:0] body_len;
    logic [7:0]       suffix;
    logic [7:0]       body0;
    logic [7:0]       body1;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign o_digits   = eff_digits;

    // classification of the current item
    always_comb begin
        // new file restarts the line state
        eff_digits     = i_in.file_start ? COUNT_ONE : r_digits;
        eff_start      = i_in.file_start || r_at_start;
        eff_last_empty = !i_in.file_start && r_last_empty;

        is_nl   = (i_in.in_byte == CH_NL);
        caret   = i_show_tabs || i_show_ends || i_show_control;
        squeeze = is_nl && eff_start && eff_last_empty && i_squeeze_blank;
        do_num  = eff_start && !squeeze &&
                  ((i_number_mode == NUM_ALL) || (i_number_mode[1] && !is_nl));

        // significant digits of the line number
        sig = IDX_W'(1);
        for (int i = 1; i < COUNT_DIGITS; i++) begin
            if (eff_digits[4*i +: 4] != 4'd0) begin
                sig = IDX_W'(i + 1);
            end
        end
        pad = (sig < IDX_W'(PAD_WIDTH)) ? IDX_W'(PAD_WIDTH) - sig : '0;

        // tab up to pad width, space one past it, nothing beyond
        if (sig <= IDX_W'(PAD_WIDTH)) begin
            suffix     = CH_TAB;
            suffix_len = IDX_W'(1);
        end else if (sig == IDX_W'(PAD_WIDTH + 1)) begin
            suffix     = CH_SPACE;
            suffix_len = IDX_W'(1);
        end else begin
            suffix     = CH_SPACE;
            suffix_len = '0;
        end

        // body bytes of the item
        body1    = CH_NL;
        body_len = IDX_W'(1);
        if (is_nl) begin
            if (i_show_ends) begin
                body0    = CH_DOLLAR;
                body_len = IDX_W'(2);
            end else begin
                body0 = CH_NL;
            end
        end else if (i_in.in_byte == CH_TAB) begin
            if (i_show_tabs) begin
                body0    = CH_CARET;
                body1    = CH_I;
                body_len = IDX_W'(2);
            end else begin
                body0 = CH_TAB;
            end
        end else if (i_in.in_byte <= CTRL_MAX && caret) begin
            body0    = CH_CARET;
            body1    = i_in.in_byte + CARET_OFFSET;
            body_len = IDX_W'(2);
        end else if (i_in.in_byte == CH_DEL && caret) begin
            body0    = CH_CARET;
            body1    = CH_QMARK;
            body_len = IDX_W'(2);
        end else begin
            body0 = i_in.in_byte;
        end

        num_end = do_num ? pad + sig + suffix_len : '0;

        o_job.empty    = squeeze;
        o_job.pad      = do_num ? pad : '0;
        o_job.dig_end  = do_num ? pad + sig : '0;
        o_job.num_end  = num_end;
        o_job.last_idx = squeeze ? '0 : num_end + body_len - IDX_W'(1);
        o_job.suffix   = suffix;
        o_job.body0    = body0;
        o_job.body1    = body1;
    end

    // bcd counter step, holds at all nines
    always_comb begin
        all_nine = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (eff_digits[4*i +: 4] != 4'd9) begin
                all_nine = 1'b0;
            end
        end
        bumped = eff_digits;
        carry  = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            dig = eff_digits[4*i +: 4];
            if (carry) begin
                if (dig >= 4'd9) begin
                    bumped[4*i +: 4] = 4'd0;
                end else begin
                    bumped[4*i +: 4] = dig + 4'd1;
                    carry            = 1'b0;
                end
            end
        end
        if (all_nine) begin
            bumped = eff_digits;
        end
    end

    // next line state
    always_comb begin
        n_digits     = do_num ? bumped : eff_digits;
        n_at_start   = eff_start;
        n_last_empty = eff_last_empty;
        if (!squeeze) begin
            if (is_nl) begin
                n_last_empty = eff_start;
                n_at_start   = 1'b1;
            end else begin
                n_at_start = 1'b0;
            end
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits     <= COUNT_ONE;
            r_at_start   <= 1'b1;
            r_last_empty <= 1'b0;
        end else if (o_push) begin
            r_digits     <= n_digits;
            r_at_start   <= n_at_start;
            r_last_empty <= n_last_empty;
        end
    end
endmodule

// File: hw/rtl/tlnvf_back.sv
// tlnvf_back: expands the queue head job into output bytes, one per cycle while
// o_out.ready is high, via an output register; depends on tlnvf_pkg, tlnvf_out_if

module tlnvf_back #(
    parameter int COUNT_DIGITS = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_avail,
    input  tlnvf_pkg::t_job           i_job,
    input  logic [4*COUNT_DIGITS-1:0] i_digits,
    output logic                      o_pop,
    tlnvf_out_if.source               o_out
);
    import tlnvf_pkg::*;

    localparam int DSEL_W = $clog2(COUNT_DIGITS);

    logic [IDX_W-1:0]  r_idx;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              r_empty;

    logic              load;
    logic              is_last;
    logic [IDX_W-1:0]  dpos;
    logic [DSEL_W-1:0] dsel;
    logic [3:0]        dig;
    logic [7:0]        n_byte;

    assign load    = i_avail && (!r_valid || o_out.ready);
    assign is_last = (r_idx == i_job.last_idx);
    assign o_pop   = load && is_last;

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.run_last  = r_last;
    assign o_out.run_empty = r_empty;

    // byte at the current run position
    always_comb begin
        dpos = i_job.dig_end - IDX_W'(1) - r_idx;
        dsel = dpos[DSEL_W-1:0];
        dig  = i_digits[4*dsel +: 4];
        if (i_job.empty) begin
            n_byte = 8'd0;
        end else if (r_idx < i_job.pad) begin
            n_byte = CH_SPACE;
        end else if (r_idx < i_job.dig_end) begin
            n_byte = CH_ZERO + {4'd0, (dig > 4'd9) ? 4'd9 : dig};
        end else if (r_idx < i_job.num_end) begin
            n_byte = i_job.suffix;
        end else if (r_idx == i_job.num_end) begin
            n_byte = i_job.body0;
        end else begin
            n_byte = i_job.body1;
        end
    end

    // run position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? '0 : r_idx + IDX_W'(1);
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= n_byte;
            r_last  <= is_last;
            r_empty <= i_job.empty;
        end
    end
endmodule

// File: hw/rtl/text_line_number_visible_filter_core.sv
// Line numbering text filter, cat style.
// Input channel i_in carries one text byte per item (in_byte, file_start);
// output channel o_out carries one formatted byte per item (out_byte,
// run_last marks the final byte of an input byte's run, run_empty marks a
// squeezed empty line whose out_byte is void). Both use valid/ready and
// move an item on a clock edge where both are high.
// Configuration: pulse i_cfg_we with i_cfg_idx 0..4 (number mode, squeeze,
// show ends, show tabs, show control) and i_cfg_data; only while idle.
// The front classifies an input byte in the cycle it is accepted and pushes
// a job into a four entry queue; the back expands the queue head at one
// output byte per cycle, stalled by the receiver, into a registered output stage.
// Throughput: an input byte takes a run of 1 to 10 output bytes, and the back
// finishes that run before it takes the next job; it emits one byte per
// cycle while the receiver is ready, so single-byte runs flow at one item
// per cycle and the back's output register sets the rate.
// Reset (synchronous, i_rst_n low) clears configuration, the queue, the
// output stage and sets the line counter to one at line start.
// When the receiver stalls, the output byte holds, the queue fills and
// i_in.ready drops once the queue is full.

module text_line_number_visible_filter_core #(
    parameter int COUNT_DIGITS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tlnvf_in_if.sink                            i_in,
    tlnvf_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [tlnvf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tlnvf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tlnvf_pkg::*;

    localparam int DIG_W = 4 * COUNT_DIGITS;
    localparam int JOB_W = $bits(t_job);
    localparam int Q_W   = DIG_W + JOB_W;

    logic [1:0]       r_number_mode;
    logic             r_squeeze_blank;
    logic             r_show_ends;
    logic             r_show_tabs;
    logic             r_show_control;

    logic             push;
    logic             q_full;
    logic             q_avail;
    logic             pop;
    t_job             front_job;
    t_job             head_job;
    logic [DIG_W-1:0] front_digits;
    logic [DIG_W-1:0] head_digits;
    logic [Q_W-1:0]   q_in;
    logic [Q_W-1:0]   q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_mode   <= NUM_NONE;
            r_squeeze_blank <= 1'b0;
            r_show_ends     <= 1'b0;
            r_show_tabs     <= 1'b0;
            r_show_control  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUMBER_MODE:   r_number_mode   <= i_cfg_data;
                CFG_SQUEEZE_BLANK: r_squeeze_blank <= i_cfg_data[0];
                CFG_SHOW_ENDS:     r_show_ends     <= i_cfg_data[0];
                CFG_SHOW_TABS:     r_show_tabs     <= i_cfg_data[0];
                CFG_SHOW_CONTROL:  r_show_control  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    tlnvf_front #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_number_mode   (r_number_mode),
        .i_squeeze_blank (r_squeeze_blank),
        .i_show_ends     (r_show_ends),
        .i_show_tabs     (r_show_tabs),
        .i_show_control  (r_show_control),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_job           (front_job),
        .o_digits        (front_digits)
    );

    // job queue
    assign q_in = {front_digits, front_job};

    tlnvf_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_data  (q_out)
    );

    assign head_digits = q_out[Q_W-1:JOB_W];
    assign head_job    = t_job'(q_out[JOB_W-1:0]);

    // back: expand into output bytes
    tlnvf_back #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (q_avail),
        .i_job    (head_job),
        .i_digits (head_digits),
        .o_pop    (pop),
        .o_out    (o_out)
    );
endmodule
